[rtl/core/lz4d_pkg.sv]
// Shared types and constants of the LZ4 block decompressor.
package lz4d_pkg;

    // Field widths.
    localparam int LEN_W = 17;
    localparam int CNT_W = 18;

    // Saturation limits of the length and byte counters.
    localparam logic [LEN_W-1:0] LEN_MAX = 17'h1FFFF;
    localparam logic [CNT_W-1:0] CNT_MAX = 18'h3FFFF;

    // Stream constants.
    localparam logic [3:0] NIB_EXT     = 4'd15;
    localparam logic [7:0] BYTE_EXT    = 8'd255;
    localparam logic [LEN_W-1:0] MIN_MATCH    = 17'd4;
    localparam logic [LEN_W-1:0] LAST_LITERALS = 17'd12;
    localparam logic [LEN_W-1:0] MATCH_TAIL    = 17'd5;

    // Item modes.
    localparam logic [1:0] MODE_DATA    = 2'd0;
    localparam logic [1:0] MODE_PULL    = 2'd1;
    localparam logic [1:0] MODE_RESTART = 2'd2;
    localparam logic [1:0] MODE_NONE    = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_DONE = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;

    // Parser phases.
    typedef enum logic [9:0] {
        PH_HDR   = 10'b00_0000_0001,
        PH_TOKEN = 10'b00_0000_0010,
        PH_LLEXT = 10'b00_0000_0100,
        PH_LIT   = 10'b00_0000_1000,
        PH_OFF0  = 10'b00_0001_0000,
        PH_OFF1  = 10'b00_0010_0000,
        PH_MLEXT = 10'b00_0100_0000,
        PH_MATCH = 10'b00_1000_0000,
        PH_RAW   = 10'b01_0000_0000,
        PH_END   = 10'b10_0000_0000
    } phase_t;

    // Next phase together with the status it reports.
    typedef struct packed {
        phase_t     ph;
        logic [1:0] st;
    } ph_st_t;

    // One result as produced by the parser, before the history read returns.
    typedef struct packed {
        logic             valid;
        logic             has_byte;
        logic             is_match;
        logic [7:0]       lit_byte;
        logic [1:0]       status;
        logic [CNT_W-1:0] consumed;
        logic             last;
    } res_t;

endpackage

[rtl/core/lz4d_hist_mem.sv]
// History memory: one write port and one registered read port.
module lz4d_hist_mem
    import lz4d_pkg::*;
#(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/lz4d_ctrl.sv]
// Stream parser: sequence state, counters and history addressing.
module lz4d_ctrl
    import lz4d_pkg::*;
#(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             acc,
    input  logic [1:0]       mode,
    input  logic [7:0]       in_byte,
    input  logic             cfg_wr_en,
    input  logic [LEN_W-1:0] cfg_wr_data,
    output res_t             res,
    output logic [AW-1:0]    rd_addr,
    output logic [AW-1:0]    wr_addr
);

    localparam int SW = ((AW > 16) ? AW : 16) + 1;
    localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
    localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);

    phase_t           phase_reg,  phase_next;
    logic [LEN_W-1:0] osize_reg;
    logic [LEN_W-1:0] pos_reg,    pos_next;
    logic [AW-1:0]    ptr_reg,    ptr_next;
    logic [LEN_W-1:0] ll_reg,     ll_next;
    logic [LEN_W-1:0] ml_reg,     ml_next;
    logic [15:0]      off_reg,    off_next;
    logic [3:0]       mn_reg,     mn_next;
    logic [CNT_W-1:0] bc_reg,     bc_next;

    // Saturating length add.
    function automatic logic [LEN_W-1:0] sat_add(input logic [LEN_W-1:0] a,
                                                 input logic [LEN_W-1:0] b);
        logic [LEN_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, LEN_MAX}) ? LEN_MAX : s[LEN_W-1:0];
    endfunction

    // Decision once all literals of a sequence are out.
    function automatic ph_st_t after_lit(input logic [LEN_W-1:0] o,
                                         input logic [LEN_W-1:0] pos_v,
                                         input logic [LEN_W-1:0] osize);
        ph_st_t r;
        if (o < LAST_LITERALS)
        begin
            r.ph = PH_END;
            r.st = (pos_v == osize) ? ST_DONE : ST_ERR;
        end
        else
        begin
            r.ph = PH_OFF0;
            r.st = ST_RUN;
        end
        return r;
    endfunction

    // Decision once the literal length is known.
    function automatic ph_st_t lit_done(input logic [LEN_W-1:0] x,
                                        input logic [LEN_W-1:0] o,
                                        input logic [LEN_W-1:0] pos_v,
                                        input logic [LEN_W-1:0] osize);
        ph_st_t r;
        if (o < x)
        begin
            r.ph = PH_END;
            r.st = ST_ERR;
        end
        else if (x == '0)
        begin
            r = after_lit(o, pos_v, osize);
        end
        else
        begin
            r.ph = PH_LIT;
            r.st = ST_RUN;
        end
        return r;
    endfunction

    logic [LEN_W-1:0] owed, owed_after, pos_inc, ll_sum, ml_sum, ml_full, dec_l, dec_m;
    logic [AW-1:0]    ptr_inc;
    logic [15:0]      off_new;
    logic [SW-1:0]    ptr_s, off_s;
    logic             bad_match;
    ph_st_t           ps;
    logic             has_c, match_c;
    logic [7:0]       byte_c;
    logic [1:0]       st_c;

    // Shared arithmetic on the current state.
    always_comb
    begin
        owed       = (osize_reg > pos_reg) ? (osize_reg - pos_reg) : '0;
        pos_inc    = (pos_reg < LEN_MAX) ? (pos_reg + 1'b1) : pos_reg;
        owed_after = (osize_reg > pos_inc) ? (osize_reg - pos_inc) : '0;
        ptr_inc    = (pos_reg < LEN_MAX) ?
                     ((ptr_reg == PTR_LAST) ? '0 : (ptr_reg + 1'b1)) : ptr_reg;
        ll_sum     = sat_add(ll_reg, {9'd0, in_byte});
        ml_sum     = sat_add(ml_reg, {9'd0, in_byte});
        dec_l      = (ll_reg != '0) ? (ll_reg - 1'b1) : '0;
        dec_m      = (ml_reg != '0) ? (ml_reg - 1'b1) : '0;
        off_new    = {in_byte, off_reg[7:0]};
        ptr_s      = SW'(ptr_reg);
        off_s      = SW'(off_reg);
        rd_addr    = (ptr_s >= off_s) ? AW'(ptr_s - off_s) : AW'(ptr_s + DEPTH_S - off_s);
        wr_addr    = ptr_reg;
    end

    // Next state and result of the item at the input.
    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        ptr_next   = ptr_reg;
        ll_next    = ll_reg;
        ml_next    = ml_reg;
        off_next   = off_reg;
        mn_next    = mn_reg;
        bc_next    = bc_reg;
        has_c      = 1'b0;
        match_c    = 1'b0;
        byte_c     = '0;
        st_c       = ST_RUN;
        ml_full    = '0;
        bad_match  = 1'b0;
        ps         = '{ph: PH_END, st: ST_RUN};

        if (mode == MODE_RESTART)
        begin
            phase_next = PH_HDR;
            pos_next   = '0;
            ptr_next   = '0;
            ll_next    = '0;
            ml_next    = '0;
            off_next   = '0;
            mn_next    = '0;
            bc_next    = '0;
        end
        else if (mode == MODE_NONE || phase_reg == PH_END)
        begin
            // Nothing happens.
        end
        else if (mode == MODE_PULL)
        begin
            if (phase_reg != PH_MATCH)
            begin
                phase_next = PH_END;
                st_c       = ST_ERR;
            end
            else
            begin
                has_c    = 1'b1;
                match_c  = 1'b1;
                pos_next = pos_inc;
                ptr_next = ptr_inc;
                ml_next  = dec_m;
                if (dec_m == '0)
                begin
                    if (owed_after < MATCH_TAIL)
                    begin
                        phase_next = PH_END;
                        st_c       = ST_ERR;
                    end
                    else
                    begin
                        phase_next = PH_TOKEN;
                    end
                end
            end
        end
        else if (phase_reg == PH_MATCH)
        begin
            phase_next = PH_END;
            st_c       = ST_ERR;
        end
        else
        begin
            if (phase_reg != PH_HDR && bc_reg < CNT_MAX)
            begin
                bc_next = bc_reg + 1'b1;
            end
            unique case (phase_reg)
                PH_HDR:
                begin
                    if (in_byte[7])
                    begin
                        if (pos_reg >= osize_reg)
                        begin
                            phase_next = PH_END;
                            st_c       = ST_DONE;
                        end
                        else
                        begin
                            phase_next = PH_RAW;
                        end
                    end
                    else
                    begin
                        phase_next = PH_TOKEN;
                    end
                end
                PH_RAW:
                begin
                    has_c    = 1'b1;
                    byte_c   = in_byte;
                    pos_next = pos_inc;
                    ptr_next = ptr_inc;
                    if (pos_inc >= osize_reg)
                    begin
                        phase_next = PH_END;
                        st_c       = ST_DONE;
                    end
                end
                PH_TOKEN:
                begin
                    ll_next = {13'd0, in_byte[7:4]};
                    mn_next = in_byte[3:0];
                    if (in_byte[7:4] == NIB_EXT)
                    begin
                        phase_next = PH_LLEXT;
                    end
                    else
                    begin
                        ps = lit_done({13'd0, in_byte[7:4]}, owed, pos_reg, osize_reg);
                        phase_next = ps.ph;
                        st_c       = ps.st;
                    end
                end
                PH_LLEXT:
                begin
                    ll_next = ll_sum;
                    if (in_byte != BYTE_EXT)
                    begin
                        ps = lit_done(ll_sum, owed, pos_reg, osize_reg);
                        phase_next = ps.ph;
                        st_c       = ps.st;
                    end
                end
                PH_LIT:
                begin
                    has_c    = 1'b1;
                    byte_c   = in_byte;
                    pos_next = pos_inc;
                    ptr_next = ptr_inc;
                    ll_next  = dec_l;
                    if (dec_l == '0)
                    begin
                        ps = after_lit(owed_after, pos_inc, osize_reg);
                        phase_next = ps.ph;
                        st_c       = ps.st;
                    end
                end
                PH_OFF0:
                begin
                    off_next   = {8'd0, in_byte};
                    phase_next = PH_OFF1;
                end
                PH_OFF1, PH_MLEXT:
                begin
                    if (phase_reg == PH_OFF1)
                    begin
                        off_next = off_new;
                        ml_next  = {13'd0, mn_reg};
                    end
                    else
                    begin
                        ml_next = ml_sum;
                    end
                    if (phase_reg == PH_OFF1 && mn_reg == NIB_EXT)
                    begin
                        phase_next = PH_MLEXT;
                    end
                    else if (phase_reg == PH_OFF1 || in_byte != BYTE_EXT)
                    begin
                        // Length is complete: add the minimum match and check it.
                        ml_full   = sat_add(ml_next, MIN_MATCH);
                        ml_next   = ml_full;
                        bad_match = (owed < ml_full) || (off_next == '0) ||
                                    ({1'b0, off_next} > pos_reg) ||
                                    (SW'(off_next) > DEPTH_S);
                        if (bad_match)
                        begin
                            phase_next = PH_END;
                            st_c       = ST_ERR;
                        end
                        else
                        begin
                            phase_next = PH_MATCH;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_END;
                    st_c       = ST_ERR;
                end
            endcase
        end

        res.valid    = has_c || (st_c != ST_RUN);
        res.has_byte = has_c;
        res.is_match = match_c;
        res.lit_byte = byte_c;
        res.status   = st_c;
        res.consumed = (st_c == ST_DONE) ? bc_next : '0;
        res.last     = (st_c != ST_RUN);
    end

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HDR;
            pos_reg   <= '0;
            ptr_reg   <= '0;
            ll_reg    <= '0;
            ml_reg    <= '0;
            off_reg   <= '0;
            mn_reg    <= '0;
            bc_reg    <= '0;
        end
        else if (acc)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            ptr_reg   <= ptr_next;
            ll_reg    <= ll_next;
            ml_reg    <= ml_next;
            off_reg   <= off_next;
            mn_reg    <= mn_next;
            bc_reg    <= bc_next;
        end
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            osize_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            osize_reg <= cfg_wr_data;
        end
    end

endmodule

[rtl/core/lz4_block_decompressor_top.sv]
// LZ4 block decompressor: one compressed or match-pull item per cycle unless
// in_stall is high. An accepted item's result passes through the middle stage
// register into the output register. A match byte's history read is issued at
// accept and written back as the middle stage advances, with forwarding.
// Reset clears the parser state, the counters and the output_size register;
// the history memory is not cleared.
module lz4_block_decompressor_top
    import lz4d_pkg::*;
#(
    parameter int HISTORY_DEPTH = 65536
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [LEN_W-1:0] cfg_wr_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [1:0]       mode,
    input  logic [7:0]       in_byte,
    output logic             out_valid,
    input  logic             out_stall,
    output logic             has_byte,
    output logic [7:0]       out_byte,
    output logic [1:0]       status,
    output logic [CNT_W-1:0] consumed,
    output logic             last
);

    localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

    res_t          res_c;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [7:0]    rdata;
    logic          acc;

    res_t          s1_res_reg;
    logic [AW-1:0] s1_addr_reg;
    logic          s1_fwd_reg;
    logic [7:0]    s1_fwd_byte_reg;
    logic [7:0]    s1_byte;
    logic          s1_adv;

    logic             out_valid_reg, out_valid_next;
    logic             has_reg;
    logic [7:0]       byte_reg;
    logic [1:0]       status_reg;
    logic [CNT_W-1:0] consumed_reg;
    logic             last_reg;

    // Handshake: the middle stage moves on when the output register frees up.
    assign s1_adv   = s1_res_reg.valid && (!out_valid_reg || !out_stall);
    assign in_stall = s1_res_reg.valid && !s1_adv;
    assign acc      = in_valid && !in_stall;

    lz4d_ctrl #(
        .DEPTH (HISTORY_DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .acc         (acc),
        .mode        (mode),
        .in_byte     (in_byte),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .res         (res_c),
        .rd_addr     (rd_addr),
        .wr_addr     (wr_addr)
    );

    // Byte of the middle stage: literal, forwarded write or memory data.
    assign s1_byte = !s1_res_reg.is_match ? s1_res_reg.lit_byte :
                     (s1_fwd_reg ? s1_fwd_byte_reg : rdata);

    lz4d_hist_mem #(
        .DEPTH (HISTORY_DEPTH),
        .AW    (AW)
    ) u_hist (
        .clk   (clk),
        .we    (s1_adv && s1_res_reg.has_byte),
        .waddr (s1_addr_reg),
        .wdata (s1_byte),
        .re    (acc && res_c.is_match),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    // Middle stage: result waiting for its history byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_res_reg <= '0;
        end
        else if (acc)
        begin
            s1_res_reg <= res_c;
        end
        else if (s1_adv)
        begin
            s1_res_reg.valid <= 1'b0;
        end
    end

    // Address and forwarding data of the middle stage.
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_addr_reg     <= wr_addr;
            s1_fwd_reg      <= s1_adv && s1_res_reg.has_byte && (s1_addr_reg == rd_addr);
            s1_fwd_byte_reg <= s1_byte;
        end
    end

    // Output register control.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            has_reg      <= s1_res_reg.has_byte;
            byte_reg     <= s1_byte;
            status_reg   <= s1_res_reg.status;
            consumed_reg <= s1_res_reg.consumed;
            last_reg     <= s1_res_reg.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign has_byte  = has_reg;
    assign out_byte  = byte_reg;
    assign status    = status_reg;
    assign consumed  = consumed_reg;
    assign last      = last_reg;

endmodule
